FILE: rtl/tfdn_pkg.sv
// shared types, field widths, register indexes and helper functions
// for the triangle face dof numbering block; no dependencies
package tfdn_pkg;

    // fixed field widths
    localparam int DEG_W      = 4;
    localparam int VID_W      = 32;
    localparam int FACE_W     = 32;
    localparam int LFACE_W    = 2;
    localparam int ORIGIN_W   = 32;
    localparam int DOF_W      = 48;
    localparam int SLOT_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int TRI_W      = 7;

    // defaults
    localparam int MAX_DEGREE_DEF  = 10;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam logic [DEG_W-1:0]    DEGREE_RST = 4'd4;
    localparam logic [ORIGIN_W-1:0] ORIGIN_RST = '0;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEGREE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN = 1'b1;

    // face orientation: rotation count plus one, negated when flipped
    typedef enum logic [2:0] {
        OR_P1,
        OR_P2,
        OR_P3,
        OR_N1,
        OR_N2,
        OR_N3
    } t_orient;

    // one classified face waiting for the back end
    typedef struct packed {
        logic [DOF_W-1:0]   base;
        t_orient            orient;
        logic [LFACE_W-1:0] lface;
    } t_entry;

    // triangular number x(x+1)/2 for a small value
    function automatic logic [TRI_W-1:0] tri_num(input logic [DEG_W-1:0] x);
        logic [7:0] p;
        p = {4'b0, x} * ({4'b0, x} + 8'd1);
        return p[7:1];
    endfunction

    // rotate until the smallest id leads, then check the winding
    function automatic t_orient orient_of(input logic [VID_W-1:0] a,
                                          input logic [VID_W-1:0] b,
                                          input logic [VID_W-1:0] c);
        logic [1:0] k;
        logic       neg;
        t_orient    o;
        if (a < b && a < c) begin
            k = 2'd0;
        end else if (b < c && b < a) begin
            k = 2'd1;
        end else if (c < a && c < b) begin
            k = 2'd2;
        end else begin
            k = 2'd0;
        end
        unique case (k)
            2'd1:    neg = (c > a);
            2'd2:    neg = (a > b);
            default: neg = (b > c);
        endcase
        unique case ({neg, k})
            3'b001:  o = OR_P2;
            3'b010:  o = OR_P3;
            3'b100:  o = OR_N1;
            3'b101:  o = OR_N2;
            3'b110:  o = OR_N3;
            default: o = OR_P1;
        endcase
        return o;
    endfunction

endpackage

FILE: rtl/tfdn_front.sv
// front end: takes faces, finds the orientation and the face base dof
// depends on tfdn_pkg
module tfdn_front
    import tfdn_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [VID_W-1:0]     i_vertex_a,
    input  logic [VID_W-1:0]     i_vertex_b,
    input  logic [VID_W-1:0]     i_vertex_c,
    input  logic [FACE_W-1:0]    i_face_index,
    input  logic [LFACE_W-1:0]   i_local_face,
    input  logic                 i_deg_ok,
    input  logic [$clog2((MAX_DEGREE-1)*(MAX_DEGREE-2)/2+1)-1:0] i_ndofs,
    input  logic [ORIGIN_W-1:0]  i_origin,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_entry               o_entry
);

    localparam int NDOF_W = $clog2((MAX_DEGREE-1)*(MAX_DEGREE-2)/2+1);
    localparam int PROD_W = FACE_W + NDOF_W;

    logic                 r_s1_valid;
    logic [VID_W-1:0]     r_s1_a;
    logic [VID_W-1:0]     r_s1_b;
    logic [VID_W-1:0]     r_s1_c;
    logic [FACE_W-1:0]    r_s1_face;
    logic [LFACE_W-1:0]   r_s1_lface;

    logic                 r_s2_valid;
    t_orient              r_s2_orient;
    logic [PROD_W-1:0]    r_s2_prod;
    logic [LFACE_W-1:0]   r_s2_lface;

    logic s1_adv;
    logic s2_adv;
    logic accept;

    // stage advance; the queue is the only stall source
    assign s2_adv = !i_q_full;
    assign s1_adv = !r_s2_valid || s2_adv;
    assign o_busy = r_s1_valid && !s1_adv;
    assign accept = i_start && !o_busy;

    // stage 1: capture the face, faces without interior nodes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= i_deg_ok;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_a     <= i_vertex_a;
            r_s1_b     <= i_vertex_b;
            r_s1_c     <= i_vertex_c;
            r_s1_face  <= i_face_index;
            r_s1_lface <= i_local_face;
        end
    end

    // stage 2: orientation code and face times ndofs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_orient <= orient_of(r_s1_a, r_s1_b, r_s1_c);
            r_s2_prod   <= PROD_W'(r_s1_face) * PROD_W'(i_ndofs);
            r_s2_lface  <= r_s1_lface;
        end
    end

    // base dof of the face goes into the queue
    assign o_push         = r_s2_valid && s2_adv;
    assign o_entry.base   = DOF_W'(i_origin) + DOF_W'(r_s2_prod);
    assign o_entry.orient = r_s2_orient;
    assign o_entry.lface  = r_s2_lface;

endmodule

FILE: rtl/tfdn_queue.sv
// short queue of classified faces between front and back end
// depends on tfdn_pkg
module tfdn_queue
    import tfdn_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_entry o_entry
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/tfdn_back.sv
// back end: walks the interior nodes of a face, one dof per cycle
// depends on tfdn_pkg
module tfdn_back
    import tfdn_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [DEG_W-1:0]     i_deg,
    input  logic [$clog2((MAX_DEGREE-1)*(MAX_DEGREE-2)/2+1)-1:0] i_ndofs,
    input  logic                 i_q_valid,
    input  t_entry               i_q_entry,
    output logic                 o_pop,
    output logic                 o_strobe,
    output logic [DOF_W-1:0]     o_dof_index,
    output logic [SLOT_W-1:0]    o_slot,
    output logic                 o_last
);

    localparam int NDOF_W = $clog2((MAX_DEGREE-1)*(MAX_DEGREE-2)/2+1);

    logic                r_valid;
    t_entry              r_entry;
    logic [DEG_W-1:0]    r_i;
    logic [DEG_W-1:0]    r_j;
    logic [NDOF_W-1:0]   r_cnt;

    logic                r_out_valid;
    logic [DOF_W-1:0]    r_dof;
    logic [SLOT_W-1:0]   r_slot;
    logic                r_last;

    logic [DEG_W-1:0]    n;
    logic [DEG_W-1:0]    m;
    logic [DEG_W-1:0]    r_pt;
    logic [DEG_W-1:0]    s_pt;
    logic [7:0]          pos;
    logic                last_now;
    logic                row_end;

    assign n        = i_deg - 1'b1;
    assign last_now = r_valid && (r_cnt == i_ndofs - 1'b1);
    assign row_end  = ((DEG_W+1)'(r_i) + (DEG_W+1)'(r_j)) == (DEG_W+1)'(n);
    assign o_pop    = i_q_valid && (!r_valid || last_now);

    // node counters: i outer, j inner, next face loads on the last node
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (last_now) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_entry <= i_q_entry;
            r_i     <= DEG_W'(1);
            r_j     <= DEG_W'(1);
            r_cnt   <= '0;
        end else if (r_valid) begin
            r_cnt <= r_cnt + 1'b1;
            if (row_end) begin
                r_i <= r_i + 1'b1;
                r_j <= DEG_W'(1);
            end else begin
                r_j <= r_j + 1'b1;
            end
        end
    end

    // map the node through the orientation to its permuted position
    always_comb begin
        m = i_deg - r_i - r_j;
        unique case (r_entry.orient)
            OR_N1:   begin r_pt = r_i; s_pt = r_j; end
            OR_P1:   begin r_pt = r_j; s_pt = r_i; end
            OR_N2:   begin r_pt = r_j; s_pt = m;   end
            OR_P2:   begin r_pt = m;   s_pt = r_j; end
            OR_N3:   begin r_pt = m;   s_pt = r_i; end
            default: begin r_pt = r_i; s_pt = m;   end
        endcase
        pos = 8'(tri_num(n - 1'b1)) - 8'(tri_num(n - r_pt)) + 8'(s_pt) - 8'd1;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_valid) begin
            r_dof  <= r_entry.base + DOF_W'(pos[NDOF_W-1:0]);
            r_slot <= SLOT_W'(r_entry.lface) * SLOT_W'(i_ndofs) + SLOT_W'(r_cnt);
            r_last <= last_now;
        end
    end

    assign o_strobe    = r_out_valid;
    assign o_dof_index = r_dof;
    assign o_slot      = r_slot;
    assign o_last      = r_last;

endmodule

FILE: rtl/triangle_face_dof_numbering.sv
// top level of the triangle face dof numbering block: config registers,
// front end, face queue and back end; depends on tfdn_pkg and submodules
//
// channel   | handshake               | fields
// ----------+-------------------------+----------------------------------------
// command   | start, busy             | vertex_a/b/c, face_index, local_face
// config    | i_cfg_we                | i_cfg_idx, i_cfg_data
// result    | o_strobe                | o_dof_index, o_slot, o_last
//
// a face gives (d-1)(d-2)/2 results at one per cycle, d the degree saturated to
// MAX_DEGREE (3 at degree 4); the back end node walker sets the rate and takes the
// next face from the queue on the last node. a face passes front stage 1, front
// stage 2, the face queue, the node counters and the result register. busy rises
// once the face queue and both front stages are full; results are never held back.
// degree below 3 takes the face and gives no result. synchronous active-low reset.
module triangle_face_dof_numbering
    import tfdn_pkg::*;
#(
    parameter int MAX_DEGREE  = MAX_DEGREE_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [VID_W-1:0]      i_vertex_a,
    input  logic [VID_W-1:0]      i_vertex_b,
    input  logic [VID_W-1:0]      i_vertex_c,
    input  logic [FACE_W-1:0]     i_face_index,
    input  logic [LFACE_W-1:0]    i_local_face,
    output logic                  o_strobe,
    output logic [DOF_W-1:0]      o_dof_index,
    output logic [SLOT_W-1:0]     o_slot,
    output logic                  o_last
);

    localparam int NDOF_W = $clog2((MAX_DEGREE-1)*(MAX_DEGREE-2)/2+1);

    logic [DEG_W-1:0]    r_degree;
    logic [ORIGIN_W-1:0] r_origin;

    logic [DEG_W-1:0]    deg_sat;
    logic                deg_ok;
    logic [NDOF_W-1:0]   ndofs;

    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_valid;
    t_entry push_entry;
    t_entry head_entry;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= DEGREE_RST;
            r_origin <= ORIGIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DEGREE: r_degree <= i_cfg_data[DEG_W-1:0];
                REG_ORIGIN: r_origin <= i_cfg_data[ORIGIN_W-1:0];
                default: ;
            endcase
        end
    end

    // saturated degree and interior node count
    assign deg_sat = (r_degree > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : r_degree;
    assign deg_ok  = (deg_sat >= DEG_W'(3));
    assign ndofs   = deg_ok ? NDOF_W'(tri_num(deg_sat - DEG_W'(2))) : '0;

    tfdn_front #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .o_busy       (busy),
        .i_vertex_a   (i_vertex_a),
        .i_vertex_b   (i_vertex_b),
        .i_vertex_c   (i_vertex_c),
        .i_face_index (i_face_index),
        .i_local_face (i_local_face),
        .i_deg_ok     (deg_ok),
        .i_ndofs      (ndofs),
        .i_origin     (r_origin),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    tfdn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    tfdn_back #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_deg       (deg_sat),
        .i_ndofs     (ndofs),
        .i_q_valid   (q_valid),
        .i_q_entry   (head_entry),
        .o_pop       (pop),
        .o_strobe    (o_strobe),
        .o_dof_index (o_dof_index),
        .o_slot      (o_slot),
        .o_last      (o_last)
    );

endmodule

FILE: rtl/tfdn_checker.sv
// port-level checks for triangle_face_dof_numbering, attached by bind
// depends on tfdn_pkg
module tfdn_checker
    import tfdn_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               busy,
    input logic               o_strobe,
    input logic [SLOT_W-1:0]  o_slot,
    input logic               o_last
);

    // nothing comes out and nothing stalls right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe && !busy)
        else $error("result or busy right after reset");

    // dofs of one face come out in consecutive cycles
    a_face_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> o_strobe)
        else $error("gap inside a face burst");

    // slot counts up by one within a face
    a_slot_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> o_slot == SLOT_W'($past(o_slot) + 1'b1))
        else $error("slot did not step by one inside a face");

endmodule

bind triangle_face_dof_numbering tfdn_checker u_tfdn_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_slot   (o_slot),
    .o_last   (o_last)
);
